FILE: rtl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg
// shared types and constants of the range minimum index tree
// ----------------------------------------------------------------------------
`default_nettype none

package rmt_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int VALUE_BITS  = 32;

  // fixed field widths of the request and result
  localparam int POS_W = 10;
  localparam int VIN_W = 32;
  localparam int CFG_W = 11;

  // derived widths
  localparam int IDX_W      = $clog2(MAX_ENTRIES);
  localparam int LEN_W      = IDX_W + 1;
  localparam int NODE_W     = IDX_W + 1;
  localparam int TREE_NODES = 1 << NODE_W;
  localparam int STK_DEPTH  = IDX_W;
  localparam int STK_W      = $clog2(STK_DEPTH);
  localparam int DEP_W      = $clog2(STK_DEPTH + 1);
  localparam int LEN_RESET  = (1024 > MAX_ENTRIES) ? MAX_ENTRIES : 1024;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [NODE_W-1:0]            node_t;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_B_INIT,
    S_B_DESC,
    S_B_RET,
    S_B_C1,
    S_B_C2,
    S_B_WR,
    S_IDLE,
    S_ROOT_V,
    S_U_DESC,
    S_U_UP,
    S_Q_SPLIT,
    S_Q_LEFT,
    S_Q_RIGHT,
    S_CAND_V,
    S_CAND_C,
    S_DONE
  } state_e;

  typedef struct packed {
    logic  we;
    node_t waddr;
    idx_t  wdata;
    logic  re;
    node_t raddr;
  } tree_req_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    value_t wdata;
    logic   re;
    idx_t   raddr;
  } val_req_t;

endpackage

`default_nettype wire

FILE: rtl/rmt_ram.sv
// ----------------------------------------------------------------------------
// rmt_ram
// simple dual-port synchronous ram, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/rmt_seq.sv
// ----------------------------------------------------------------------------
// rmt_seq
// sequencer: clear, rebuild, point update and range query over the two rams
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_seq (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             op_i,
  input  wire logic [rmt_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [rmt_pkg::VIN_W-1:0] new_value_i,
  input  wire logic [rmt_pkg::POS_W-1:0]        range_start_i,
  input  wire logic [rmt_pkg::POS_W-1:0]        range_end_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [rmt_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [rmt_pkg::POS_W-1:0]             min_index_o,
  output logic                                  found_o,
  output rmt_pkg::tree_req_t                    tree_req_o,
  input  wire rmt_pkg::idx_t                    tree_rdata_i,
  output rmt_pkg::val_req_t                     val_req_o,
  input  wire rmt_pkg::value_t                  val_rdata_i
);

  import rmt_pkg::*;

  state_e state_q, state_d;
  state_e ret_q, ret_d;

  logic [LEN_W-1:0] len_q, len_d;
  idx_t             clr_q, clr_d;
  node_t            k_q, k_d;
  idx_t             lo_q, lo_d;
  idx_t             hi_q, hi_d;
  logic [DEP_W-1:0] d_q, d_d;
  idx_t             stk_lo_q [STK_DEPTH];
  idx_t             stk_hi_q [STK_DEPTH];
  idx_t             pos_q, pos_d;
  idx_t             s_q, s_d;
  idx_t             e_q, e_d;
  node_t            rk_q, rk_d;
  idx_t             rlo_q, rlo_d;
  idx_t             rhi_q, rhi_d;
  idx_t             cidx_q, cidx_d;
  logic             acc_found_q, acc_found_d;
  idx_t             acc_idx_q, acc_idx_d;
  value_t           acc_val_q, acc_val_d;
  logic             out_valid_q, out_valid_d;
  idx_t             out_idx_q, out_idx_d;
  logic             out_found_q, out_found_d;

  logic             accept;
  logic             upd_ok;
  logic             q_ok;
  logic [31:0]      last32;
  logic [31:0]      end32;
  idx_t             last;
  logic [IDX_W:0]   span_sum;
  idx_t             mid;
  idx_t             mid_p1;
  node_t            k2;
  node_t            k2p1;
  logic [DEP_W-1:0] dm1;
  logic             leaf;
  logic             stk_push;
  logic             cand_go;
  node_t            cand_node;
  logic             out_load;
  logic             take;

  // shared datapath terms
  assign last     = IDX_W'(len_q - LEN_W'(1));
  assign last32   = 32'(last);
  assign end32    = (32'(range_end_i) > last32) ? last32 : 32'(range_end_i);
  assign accept   = in_valid_i && !in_stall_o;
  assign upd_ok   = 32'(position_i) < 32'(len_q);
  assign q_ok     = 32'(range_start_i) <= end32;
  assign span_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = span_sum[IDX_W:1];
  assign mid_p1   = IDX_W'(mid + 1'b1);
  assign k2       = {k_q[NODE_W-2:0], 1'b0};
  assign k2p1     = {k_q[NODE_W-2:0], 1'b1};
  assign dm1      = DEP_W'(d_q - 1'b1);
  assign leaf     = lo_q == hi_q;
  assign take     = !acc_found_q || (val_rdata_i < acc_val_q) ||
                    ((val_rdata_i == acc_val_q) && (cidx_q < acc_idx_q));

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    len_d       = len_q;
    clr_d       = clr_q;
    k_d         = k_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    d_d         = d_q;
    pos_d       = pos_q;
    s_d         = s_q;
    e_d         = e_q;
    rk_d        = rk_q;
    rlo_d       = rlo_q;
    rhi_d       = rhi_q;
    cidx_d      = cidx_q;
    acc_found_d = acc_found_q;
    acc_idx_d   = acc_idx_q;
    acc_val_d   = acc_val_q;
    stk_push    = 1'b0;
    cand_go     = 1'b0;
    cand_node   = k_q;
    out_load    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        clr_d = IDX_W'(clr_q + 1'b1);
        if (clr_q == IDX_W'(MAX_ENTRIES - 1)) begin
          state_d = S_B_INIT;
        end
      end
      S_B_INIT: begin
        k_d     = NODE_W'(1);
        lo_d    = '0;
        hi_d    = last;
        d_d     = '0;
        state_d = S_B_DESC;
      end
      S_B_DESC: begin
        if (leaf) begin
          state_d = S_B_RET;
        end else begin
          stk_push = 1'b1;
          d_d      = DEP_W'(d_q + 1'b1);
          k_d      = k2;
          hi_d     = mid;
        end
      end
      S_B_RET: begin
        priority if (k_q == NODE_W'(1)) begin
          state_d = S_IDLE;
        end else if (!k_q[0]) begin
          k_d     = NODE_W'(k_q + 1'b1);
          lo_d    = IDX_W'(hi_q + 1'b1);
          hi_d    = stk_hi_q[dm1[STK_W-1:0]];
          state_d = S_B_DESC;
        end else begin
          d_d         = dm1;
          k_d         = {1'b0, k_q[NODE_W-1:1]};
          lo_d        = stk_lo_q[dm1[STK_W-1:0]];
          hi_d        = stk_hi_q[dm1[STK_W-1:0]];
          acc_found_d = 1'b0;
          state_d     = S_B_C1;
        end
      end
      S_B_C1: begin
        cand_go   = 1'b1;
        cand_node = k2;
        ret_d     = S_B_C2;
        state_d   = S_CAND_V;
      end
      S_B_C2: begin
        cand_go   = 1'b1;
        cand_node = k2p1;
        ret_d     = S_B_WR;
        state_d   = S_CAND_V;
      end
      S_B_WR: begin
        state_d = S_B_RET;
      end
      S_IDLE: begin
        if (accept) begin
          if (op_i == OP_UPDATE) begin
            acc_found_d = 1'b1;
            if (upd_ok) begin
              pos_d     = IDX_W'(position_i);
              acc_idx_d = IDX_W'(position_i);
              acc_val_d = VALUE_BITS'(new_value_i);
              k_d       = NODE_W'(1);
              lo_d      = '0;
              hi_d      = last;
              state_d   = S_U_DESC;
            end else begin
              state_d = S_ROOT_V;
            end
          end else begin
            acc_found_d = 1'b0;
            if (q_ok) begin
              s_d     = IDX_W'(range_start_i);
              e_d     = IDX_W'(end32);
              k_d     = NODE_W'(1);
              lo_d    = '0;
              hi_d    = last;
              state_d = S_Q_SPLIT;
            end else begin
              acc_idx_d = '0;
              state_d   = S_DONE;
            end
          end
        end
      end
      S_ROOT_V: begin
        acc_idx_d = tree_rdata_i;
        state_d   = S_DONE;
      end
      S_U_DESC: begin
        priority if (leaf) begin
          state_d = S_U_UP;
        end else if (pos_q <= mid) begin
          k_d  = k2;
          hi_d = mid;
        end else begin
          k_d  = k2p1;
          lo_d = mid_p1;
        end
      end
      S_U_UP: begin
        if (k_q == NODE_W'(1)) begin
          state_d = S_DONE;
        end else begin
          cand_go   = 1'b1;
          cand_node = {k_q[NODE_W-1:1], ~k_q[0]};
          ret_d     = S_U_UP;
          k_d       = {1'b0, k_q[NODE_W-1:1]};
          state_d   = S_CAND_V;
        end
      end
      S_Q_SPLIT: begin
        priority if (s_q <= lo_q && hi_q <= e_q) begin
          cand_go   = 1'b1;
          cand_node = k_q;
          ret_d     = S_DONE;
          state_d   = S_CAND_V;
        end else if (e_q <= mid) begin
          k_d  = k2;
          hi_d = mid;
        end else if (s_q > mid) begin
          k_d  = k2p1;
          lo_d = mid_p1;
        end else begin
          rk_d    = k2p1;
          rlo_d   = mid_p1;
          rhi_d   = hi_q;
          k_d     = k2;
          hi_d    = mid;
          state_d = S_Q_LEFT;
        end
      end
      S_Q_LEFT: begin
        priority if (s_q <= lo_q) begin
          cand_go   = 1'b1;
          cand_node = k_q;
          ret_d     = S_Q_RIGHT;
          k_d       = rk_q;
          lo_d      = rlo_q;
          hi_d      = rhi_q;
          state_d   = S_CAND_V;
        end else if (s_q <= mid) begin
          cand_go   = 1'b1;
          cand_node = k2p1;
          ret_d     = S_Q_LEFT;
          k_d       = k2;
          hi_d      = mid;
          state_d   = S_CAND_V;
        end else begin
          k_d  = k2p1;
          lo_d = mid_p1;
        end
      end
      S_Q_RIGHT: begin
        priority if (hi_q <= e_q) begin
          cand_go   = 1'b1;
          cand_node = k_q;
          ret_d     = S_DONE;
          state_d   = S_CAND_V;
        end else if (e_q > mid) begin
          cand_go   = 1'b1;
          cand_node = k2;
          ret_d     = S_Q_RIGHT;
          k_d       = k2p1;
          lo_d      = mid_p1;
          state_d   = S_CAND_V;
        end else begin
          k_d  = k2;
          hi_d = mid;
        end
      end
      S_CAND_V: begin
        cidx_d  = tree_rdata_i;
        state_d = S_CAND_C;
      end
      S_CAND_C: begin
        if (take) begin
          acc_found_d = 1'b1;
          acc_idx_d   = cidx_q;
          acc_val_d   = val_rdata_i;
        end
        state_d = ret_q;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // a length write rebuilds the tree
    if (cfg_we_i) begin
      priority if (32'(cfg_wdata_i) == 32'd0) begin
        len_d = LEN_W'(1);
      end else if (32'(cfg_wdata_i) > 32'(MAX_ENTRIES)) begin
        len_d = LEN_W'(MAX_ENTRIES);
      end else begin
        len_d = LEN_W'(cfg_wdata_i);
      end
      if (state_q != S_CLEAR) begin
        state_d = S_B_INIT;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_load || (out_valid_q && out_stall_i);
    out_idx_d   = out_load ? acc_idx_q : out_idx_q;
    out_found_d = out_load ? acc_found_q : out_found_q;
  end

  // memory requests and handshake
  always_comb begin
    in_stall_o = (state_q != S_IDLE) || cfg_we_i;
    tree_req_o = '0;
    val_req_o  = '0;
    unique case (state_q)
      S_CLEAR: begin
        val_req_o.we    = 1'b1;
        val_req_o.waddr = clr_q;
        val_req_o.wdata = '0;
      end
      S_B_DESC: begin
        tree_req_o.we    = leaf;
        tree_req_o.waddr = k_q;
        tree_req_o.wdata = lo_q;
      end
      S_B_WR, S_U_UP: begin
        tree_req_o.we    = 1'b1;
        tree_req_o.waddr = k_q;
        tree_req_o.wdata = acc_idx_q;
      end
      S_IDLE: begin
        tree_req_o.re    = 1'b1;
        tree_req_o.raddr = NODE_W'(1);
        val_req_o.we     = accept && (op_i == OP_UPDATE) && upd_ok;
        val_req_o.waddr  = IDX_W'(position_i);
        val_req_o.wdata  = VALUE_BITS'(new_value_i);
      end
      S_CAND_V: begin
        val_req_o.re    = 1'b1;
        val_req_o.raddr = tree_rdata_i;
      end
      default: begin
      end
    endcase
    if (cand_go) begin
      tree_req_o.re    = 1'b1;
      tree_req_o.raddr = cand_node;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      len_q       <= LEN_W'(LEN_RESET);
      clr_q       <= '0;
      d_q         <= '0;
      acc_found_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      len_q       <= len_d;
      clr_q       <= clr_d;
      d_q         <= d_d;
      acc_found_q <= acc_found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q       <= k_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    pos_q     <= pos_d;
    s_q       <= s_d;
    e_q       <= e_d;
    rk_q      <= rk_d;
    rlo_q     <= rlo_d;
    rhi_q     <= rhi_d;
    cidx_q    <= cidx_d;
    acc_idx_q <= acc_idx_d;
    acc_val_q <= acc_val_d;
    out_idx_q   <= out_idx_d;
    out_found_q <= out_found_d;
    if (stk_push) begin
      stk_lo_q[d_q[STK_W-1:0]] <= lo_q;
      stk_hi_q[d_q[STK_W-1:0]] <= hi_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_index_o = POS_W'(out_idx_q);
  assign found_o     = out_found_q;

endmodule

`default_nettype wire

FILE: rtl/range_min_index_tree_core.sv
// ----------------------------------------------------------------------------
// range_min_index_tree_core
// Leftmost-minimum index tree over an array of signed values. A point update
// writes a value and returns the index of the minimum over the whole used
// array; a range query returns the leftmost index of the minimum over
// [range_start, range_end], clipped to used_length, with found low when the
// range is empty. Values and node winners sit in two rams with a registered
// read, and one request is worked on at a time. Every candidate node costs a
// tree read followed by a value read. After reset the block stalls requests
// for a clearing pass over all 1024 value entries and then a tree rebuild
// over the used entries; every used_length write triggers the same rebuild.
// A result waiting in the output register does not hold back the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module range_min_index_tree_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             op_i,
  input  wire logic [rmt_pkg::POS_W-1:0]        position_i,
  input  wire logic signed [rmt_pkg::VIN_W-1:0] new_value_i,
  input  wire logic [rmt_pkg::POS_W-1:0]        range_start_i,
  input  wire logic [rmt_pkg::POS_W-1:0]        range_end_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [rmt_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [rmt_pkg::POS_W-1:0]             min_index_o,
  output logic                                  found_o
);

  import rmt_pkg::*;

  tree_req_t tree_req;
  val_req_t  val_req;
  idx_t      tree_rdata;
  value_t    val_rdata;

  rmt_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .position_i    (position_i),
    .new_value_i   (new_value_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .min_index_o   (min_index_o),
    .found_o       (found_o),
    .tree_req_o    (tree_req),
    .tree_rdata_i  (tree_rdata),
    .val_req_o     (val_req),
    .val_rdata_i   (val_rdata)
  );

  // node winners
  rmt_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TREE_NODES)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (tree_req.we),
    .waddr_i (tree_req.waddr),
    .wdata_i (tree_req.wdata),
    .re_i    (tree_req.re),
    .raddr_i (tree_req.raddr),
    .rdata_o (tree_rdata)
  );

  // stored values
  rmt_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_req.we),
    .waddr_i (val_req.waddr),
    .wdata_i (val_req.wdata),
    .re_i    (val_req.re),
    .raddr_i (val_req.raddr),
    .rdata_o (val_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/rmt_checker.sv
// ----------------------------------------------------------------------------
// rmt_checker
// port-level checks of the range minimum index tree
// ----------------------------------------------------------------------------
`default_nettype none

module rmt_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic                             op_i,
  input wire logic [rmt_pkg::POS_W-1:0]        position_i,
  input wire logic signed [rmt_pkg::VIN_W-1:0] new_value_i,
  input wire logic [rmt_pkg::POS_W-1:0]        range_start_i,
  input wire logic [rmt_pkg::POS_W-1:0]        range_end_i,
  input wire logic                             cfg_we_i,
  input wire logic [rmt_pkg::CFG_W-1:0]        cfg_wdata_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic [rmt_pkg::POS_W-1:0]        min_index_o,
  input wire logic                             found_o
);

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one still in work");

  // a length write starts a rebuild
  a_cfg_rebuild: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> in_stall_o)
    else $error("no rebuild after length write");

  // an empty result carries index zero
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (min_index_o == '0))
    else $error("not-found result with nonzero index");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(min_index_o) && $stable(found_o)))
    else $error("stalled result changed");

endmodule

bind range_min_index_tree_core rmt_checker u_chk (.*);

`default_nettype wire
